/* sv/pis_pkg.sv */
// Shared types and constants of the pyro igniter sequencer.
// Used by every module of the block; depends on nothing.
package pis_pkg;

  localparam int MAX_CH = 4;
  localparam int IN_W   = 160;
  localparam int OUT_W  = 24;
  localparam int RES_W  = 20;
  localparam int CFG_W  = 23;
  localparam int CIDX_W = 3;

  localparam logic [1:0] FS_OTHER     = 2'd0;
  localparam logic [1:0] FS_STANDING  = 2'd1;
  localparam logic [1:0] FS_FREE_FALL = 2'd2;
  // Not a defined flight state; the sequencer treats it like FS_OTHER.
  localparam logic [1:0] FS_SPARE     = 2'd3;

  typedef enum logic [CIDX_W-1:0] {
    REG_DESCENT_LIM = 3'd0,
    REG_MAIN_HEIGHT = 3'd1,
    REG_PULSE_MS    = 3'd2,
    REG_ADC_DEAD_MS = 3'd3,
    REG_THR_BOTH    = 3'd4,
    REG_THR_FUSE    = 3'd5,
    REG_THR_IGN     = 3'd6
  } cfg_idx_t;

  // Declared from the highest bit down so a cast of the stream word lines up.
  typedef struct packed {
    logic [63:0]        chan_mv_packed;
    logic [15:0]        bat_mv;
    logic               bat_empty;
    logic               adc_valid;
    logic [2:0]         test_channel;
    logic               test_req;
    logic signed [23:0] alt_up;
    logic signed [15:0] vel_up;
    logic [1:0]         flight_state;
    logic [31:0]        time_ms;
  } item_t;

  typedef struct packed {
    logic [7:0] cont_flags;
    logic       cont_publish;
    logic       test_done;
    logic       test_rejected;
    logic       fired_publish;
    logic [3:0] fired_mask;
    logic [3:0] pin_drive;
  } res_t;

  typedef struct packed {
    logic [14:0] descent_limit;
    logic [22:0] main_deploy_height;
    logic [15:0] pulse_ms;
    logic [15:0] adc_dead_ms;
    logic [15:0] thr_both_ok;
    logic [15:0] thr_fuse_only;
    logic [15:0] thr_ign_only;
  } cfg_t;

  // Battery voltage scaled by each continuity threshold.
  typedef struct packed {
    logic [31:0] both_ok;
    logic [31:0] fuse_only;
    logic [31:0] ign_only;
  } prod_t;

endpackage

/* sv/pyro_igniter_sequencer_core.sv */
// Top level of the pyro igniter sequencer: stream ports, configuration
// registers and the three-register item pipeline. Depends on pis_pkg,
// pis_mul and pis_seq.
//
//   channel   dir   signals                     content
//   s_axis    in    s_tvalid s_tready s_tdata   one control tick
//   m_axis    out   m_tvalid m_tready m_tdata   one result per tick
//   cfg       in    cfg_we cfg_idx cfg_wdata    register writes, no read-back
//
// An item passes an input register, a threshold multiply register and the
// result register, one item per cycle sustained while the output is not
// stalled. Sequencer state is read and updated only as an item moves into
// the result register. Reset (rst, synchronous) empties the pipeline,
// clears sequencer state and loads register defaults. A stalled output
// holds the pipeline; the input keeps accepting until every register is full.
module pyro_igniter_sequencer_core
  import pis_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // time_ms[31:0], flight_state[33:32], vel_up[49:34], alt_up[73:50],
  // test_req[74], test_channel[77:75], adc_valid[78], bat_empty[79],
  // bat_mv[95:80], chan_mv_packed[159:96]
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // pin_drive[3:0], fired_mask[7:4], fired_publish[8], test_rejected[9],
  // test_done[10], cont_publish[11], cont_flags[19:12], zero[23:20]
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  cfg_t  cfg;
  item_t item1, item2;
  prod_t prod;
  res_t  res_comb, res;
  logic  v1, v2;
  logic  out_free, adv2, step;

  assign out_free = !m_tvalid || m_tready;
  assign adv2     = !v2 || out_free;
  assign s_tready = !v1 || adv2;
  assign step     = v2 && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.descent_limit      <= 15'd5000;
      cfg.main_deploy_height <= 23'd3000;
      cfg.pulse_ms           <= 16'd1000;
      cfg.adc_dead_ms        <= 16'd1000;
      cfg.thr_both_ok        <= 16'd16384;
      cfg.thr_fuse_only      <= 16'd32768;
      cfg.thr_ign_only       <= 16'd49152;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        REG_DESCENT_LIM: cfg.descent_limit      <= cfg_wdata[14:0];
        REG_MAIN_HEIGHT: cfg.main_deploy_height <= cfg_wdata[22:0];
        REG_PULSE_MS:    cfg.pulse_ms           <= cfg_wdata[15:0];
        REG_ADC_DEAD_MS: cfg.adc_dead_ms        <= cfg_wdata[15:0];
        REG_THR_BOTH:    cfg.thr_both_ok        <= cfg_wdata[15:0];
        REG_THR_FUSE:    cfg.thr_fuse_only      <= cfg_wdata[15:0];
        REG_THR_IGN:     cfg.thr_ign_only       <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) v1 <= s_tvalid;
      if (adv2) v2 <= v1;
      if (out_free) m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item1 <= item_t'(s_tdata);
    end
    if (step) begin
      res <= res_comb;
    end
  end

  pis_mul u_mul (
    .clk      (clk),
    .en       (v1 && adv2),
    .item_in  (item1),
    .cfg      (cfg),
    .item_out (item2),
    .prod     (prod)
  );

  pis_seq #(
    .CHANNELS (CHANNELS)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item2),
    .prod (prod),
    .cfg  (cfg),
    .res  (res_comb)
  );

  assign m_tdata = {(OUT_W - RES_W)'(0), res};

endmodule

/* sv/pis_mul.sv */
// Threshold scaling stage: registers the item together with bat_mv times
// each of the three continuity thresholds. Depends on pis_pkg.
module pis_mul
  import pis_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  item_t item_in,
  input  cfg_t  cfg,
  output item_t item_out,
  output prod_t prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      item_out       <= item_in;
      prod.both_ok   <= {16'h0000, item_in.bat_mv} * {16'h0000, cfg.thr_both_ok};
      prod.fuse_only <= {16'h0000, item_in.bat_mv} * {16'h0000, cfg.thr_fuse_only};
      prod.ign_only  <= {16'h0000, item_in.bat_mv} * {16'h0000, cfg.thr_ign_only};
    end
  end

endmodule

/* sv/pis_cont.sv */
// Continuity classifier: compares each channel's sense voltage against the
// battery-scaled thresholds. Combinational; depends on pis_pkg.
module pis_cont
  import pis_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic [63:0]       chan_mv,
  input  prod_t             prod,
  input  logic [MAX_CH-1:0] drive,
  input  logic              bat_empty,
  output logic [7:0]        flags
);

  always_comb begin
    logic [31:0] v;
    logic [1:0]  f;
    flags = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      v = {chan_mv[16*i +: 16], 16'h0000};
      if (v < prod.both_ok)        f = 2'd3;
      else if (v < prod.fuse_only) f = 2'd2;
      else if (v < prod.ign_only)  f = 2'd1;
      else                         f = 2'd0;
      // A driven channel or an empty battery reads as nothing connected.
      if (bat_empty || drive[i]) f = 2'd0;
      flags[2*i +: 2] = f;
    end
  end

endmodule

/* sv/pis_seq.sv */
// Sequencer state and per-tick logic: flight firing, test requests, pulse
// ends, fired status and continuity timing. Depends on pis_pkg, pis_cont.
module pis_seq
  import pis_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  input  prod_t prod,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0] fired, finished;
  logic [31:0]         fire_time [CHANNELS];
  logic                apogee_seen;
  logic                test_active;
  logic [IDX_W-1:0]    test_index;
  logic [31:0]         last_cont_time;

  logic [CHANNELS-1:0] fire_fl, fired_a, test_hit, test_fire, fire_now, fired_b;
  logic [CHANNELS-1:0] expired, is_test, done_ch, fin_ch, fired_next, finished_next;
  logic [CHANNELS-1:0] drive;
  logic [31:0]         elapsed [CHANNELS];
  logic                free_fall, standing, vel_low, alt_low;
  logic signed [16:0]  vel_ext, lim_ext;
  logic                test_go, active_b, test_active_next;
  logic [IDX_W-1:0]    req_idx, index_b;
  logic                cont_pub;
  logic [31:0]         last_cont_time_next;
  logic [7:0]          cont_flags;

  assign free_fall = item.flight_state == FS_FREE_FALL;
  assign standing  = item.flight_state == FS_STANDING;
  assign vel_ext   = {item.vel_up[15], item.vel_up};
  assign lim_ext   = 17'sd0 - $signed({2'b00, cfg.descent_limit});
  assign vel_low   = vel_ext <= lim_ext;
  assign alt_low   = item.alt_up <= $signed({1'b0, cfg.main_deploy_height});
  assign req_idx   = IDX_W'(item.test_channel - 3'd1);

  always_comb begin
    fire_fl    = '0;
    fire_fl[0] = free_fall && !apogee_seen && !fired[0] && !finished[0];
    fire_fl[1] = free_fall && !fired[1] && !finished[1] && (vel_low || alt_low);
    fired_a    = fired | fire_fl;
    for (int i = 0; i < CHANNELS; i++) begin
      test_hit[i] = item.test_channel == 3'(i + 1);
    end
    test_go   = item.test_req && standing && !test_active && (|test_hit) &&
                !(|(test_hit & (fired_a | finished)));
    test_fire = test_go ? test_hit : '0;
    fire_now  = fire_fl | test_fire;
    fired_b   = fired | fire_now;
    active_b  = test_active || test_go;
    index_b   = test_go ? req_idx : test_index;
    for (int i = 0; i < CHANNELS; i++) begin
      // A channel fired on this tick has no time elapsed yet.
      elapsed[i] = fire_now[i] ? 32'd0 : item.time_ms - fire_time[i];
      expired[i] = fired_b[i] && !finished[i] && (elapsed[i] >= {16'h0000, cfg.pulse_ms});
      is_test[i] = active_b && (index_b == IDX_W'(i));
    end
    done_ch          = expired & is_test;
    fin_ch           = expired & ~is_test;
    fired_next       = fired_b & ~done_ch;
    finished_next    = finished | fin_ch;
    test_active_next = active_b && !(|done_ch);
    drive            = fired_next & ~finished_next;
  end

  pis_cont #(
    .CHANNELS (CHANNELS)
  ) u_cont (
    .chan_mv   (item.chan_mv_packed),
    .prod      (prod),
    .drive     (MAX_CH'(drive)),
    .bat_empty (item.bat_empty),
    .flags     (cont_flags)
  );

  always_comb begin
    if (item.adc_valid) begin
      cont_pub = 1'b1;
    end else begin
      cont_pub = (item.time_ms - last_cont_time) >= {16'h0000, cfg.adc_dead_ms};
    end
    last_cont_time_next = cont_pub ? item.time_ms : last_cont_time;
  end

  always_comb begin
    res.pin_drive     = MAX_CH'(drive);
    res.fired_publish = (|fire_now) || (|done_ch);
    res.fired_mask    = res.fired_publish ? MAX_CH'(fired_next) : '0;
    res.test_rejected = item.test_req && !test_go;
    res.test_done     = |done_ch;
    res.cont_publish  = cont_pub;
    res.cont_flags    = item.adc_valid ? cont_flags : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fired          <= '0;
      finished       <= '0;
      apogee_seen    <= 1'b0;
      test_active    <= 1'b0;
      test_index     <= '0;
      last_cont_time <= '0;
    end else if (step) begin
      fired          <= fired_next;
      finished       <= finished_next;
      apogee_seen    <= apogee_seen || free_fall;
      test_active    <= test_active_next;
      test_index     <= index_b;
      last_cont_time <= last_cont_time_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (rst) begin
        fire_time[i] <= '0;
      end else if (step && fire_now[i]) begin
        fire_time[i] <= item.time_ms;
      end
    end
  end

endmodule

/* tb/sv/tb_pyro_igniter_sequencer_core.sv */
// Self-checking testbench for the pyro igniter sequencer core: directed and random ticks,
// with an in-bench prediction of every result.
// Depends on pis_pkg and pyro_igniter_sequencer_core.
module tb_pyro_igniter_sequencer_core;
  import pis_pkg::*;

  localparam int CHANNELS = 4;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_idx = REG_DESCENT_LIM;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  pyro_igniter_sequencer_core #(.CHANNELS(CHANNELS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predicted sequencer state and register copy.
  cfg_t        regs = '{15'd5000, 23'd3000, 16'd1000, 16'd1000,
                        16'd16384, 16'd32768, 16'd49152};
  logic [3:0]  chan_fired = '0;
  logic [3:0]  chan_finished = '0;
  logic [31:0] fire_time [4] = '{default: '0};
  logic        apogee_seen = 1'b0;
  logic        test_active = 1'b0;
  logic [1:0]  test_index = '0;
  logic [31:0] last_cont_time = '0;

  res_t        tick_results_due [$];
  int          mismatch_count = 0;
  logic [31:0] now_ms = '0;
  int          burst_left = 0;
  int          stall_left = 0;
  logic        tx_steady = 1'b0;
  logic        rx_steady = 1'b0;

  function automatic logic ignite(input int ch, input logic [31:0] at_ms);
    if (ch >= CHANNELS || chan_fired[ch] || chan_finished[ch]) return 1'b0;
    chan_fired[ch] = 1'b1;
    fire_time[ch] = at_ms;
    return 1'b1;
  endfunction

  // Advances the predicted state by one tick and returns the result it produces.
  function automatic res_t sequence_tick(input item_t t);
    res_t        r;
    logic        changed;
    int          vel, alt;
    logic [1:0]  idx, f;
    logic [31:0] elapsed;
    logic [63:0] sense, bat;
    r = '0;
    changed = 1'b0;
    vel = $signed(t.vel_up);
    alt = $signed(t.alt_up);
    if (t.flight_state == FS_FREE_FALL) begin
      if (!apogee_seen) begin
        changed |= ignite(0, t.time_ms);
        apogee_seen = 1'b1;
      end
      if (!chan_fired[1] && (vel <= -int'(regs.descent_limit) ||
                             alt <= int'(regs.main_deploy_height)))
        changed |= ignite(1, t.time_ms);
    end
    if (t.test_req) begin
      if (t.flight_state != FS_STANDING) begin
        r.test_rejected = 1'b1;
      end else if (!test_active && t.test_channel >= 1 && t.test_channel <= CHANNELS) begin
        idx = 2'(t.test_channel - 3'd1);
        if (chan_fired[idx] || chan_finished[idx]) begin
          r.test_rejected = 1'b1;
        end else begin
          test_active = 1'b1;
          test_index = idx;
          changed |= ignite(int'(idx), t.time_ms);
        end
      end else begin
        r.test_rejected = 1'b1;
      end
    end
    for (int i = 0; i < CHANNELS; i++) begin
      elapsed = t.time_ms - fire_time[i];
      if (chan_fired[i] && !chan_finished[i] && elapsed >= {16'd0, regs.pulse_ms}) begin
        // A finished test pulse puts its channel back in service.
        if (test_active && test_index == i) begin
          test_active = 1'b0;
          changed = 1'b1;
          chan_fired[i] = 1'b0;
          r.test_done = 1'b1;
        end else begin
          chan_finished[i] = 1'b1;
        end
      end
    end
    r.pin_drive = chan_fired & ~chan_finished;
    r.fired_publish = changed;
    r.fired_mask = changed ? chan_fired : 4'd0;
    if (!t.adc_valid) begin
      elapsed = t.time_ms - last_cont_time;
      if (elapsed >= {16'd0, regs.adc_dead_ms}) begin
        last_cont_time = t.time_ms;
        r.cont_publish = 1'b1;
      end
    end else begin
      bat = {48'd0, t.bat_mv};
      for (int i = 0; i < CHANNELS; i++) begin
        f = 2'd0;
        if (!t.bat_empty && !(chan_fired[i] && !chan_finished[i])) begin
          sense = {32'd0, t.chan_mv_packed[16*i +: 16], 16'd0};
          if (sense < bat * regs.thr_both_ok) f = 2'd3;
          else if (sense < bat * regs.thr_fuse_only) f = 2'd2;
          else if (sense < bat * regs.thr_ign_only) f = 2'd1;
        end
        r.cont_flags[2*i +: 2] = f;
      end
      last_cont_time = t.time_ms;
      r.cont_publish = 1'b1;
    end
    return r;
  endfunction

  // Output side: stalls in runs of random length, or stays ready during steady stretches.
  always @(negedge clk) begin
    if (rx_steady) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[RES_W-1:0]);
      if (tick_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item %h with nothing outstanding", m_tdata);
      end else begin
        want = tick_results_due.pop_front();
        if (got.pin_drive !== want.pin_drive || got.fired_mask !== want.fired_mask ||
            got.fired_publish !== want.fired_publish ||
            got.test_rejected !== want.test_rejected || got.test_done !== want.test_done ||
            got.cont_publish !== want.cont_publish || got.cont_flags !== want.cont_flags ||
            m_tdata[OUT_W-1:RES_W] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %h actual %h",
                     {(OUT_W - RES_W)'(0), want}, m_tdata);
        end
      end
    end
  end

  task automatic send_tick(input item_t t);
    @(negedge clk);
    if (!tx_steady && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    do @(posedge clk); while (!s_tready);
    tick_results_due.push_back(sequence_tick(t));
  endtask

  // Stops sending and waits until every outstanding result has come out.
  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
  endtask

  // Only called with the pipeline empty.
  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_DESCENT_LIM: regs.descent_limit      = val[14:0];
      REG_MAIN_HEIGHT: regs.main_deploy_height = val[22:0];
      REG_PULSE_MS:    regs.pulse_ms           = val[15:0];
      REG_ADC_DEAD_MS: regs.adc_dead_ms        = val[15:0];
      REG_THR_BOTH:    regs.thr_both_ok        = val[15:0];
      REG_THR_FUSE:    regs.thr_fuse_only      = val[15:0];
      REG_THR_IGN:     regs.thr_ign_only       = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input cfg_t c);
    wait_results_drained();
    set_reg(REG_DESCENT_LIM, CFG_W'(c.descent_limit));
    set_reg(REG_MAIN_HEIGHT, CFG_W'(c.main_deploy_height));
    set_reg(REG_PULSE_MS,    CFG_W'(c.pulse_ms));
    set_reg(REG_ADC_DEAD_MS, CFG_W'(c.adc_dead_ms));
    set_reg(REG_THR_BOTH,    CFG_W'(c.thr_both_ok));
    set_reg(REG_THR_FUSE,    CFG_W'(c.thr_fuse_only));
    set_reg(REG_THR_IGN,     CFG_W'(c.thr_ign_only));
  endtask

  // A standing tick with fresh readings, no request and all channels reading 0 mV.
  function automatic item_t quiet_tick(input logic [31:0] at_ms);
    item_t t;
    t = '0;
    t.time_ms = at_ms;
    t.flight_state = FS_STANDING;
    t.alt_up = 24'sd10000;
    t.adc_valid = 1'b1;
    t.bat_mv = 16'd4000;
    return t;
  endfunction

  function automatic item_t test_request(input logic [31:0] at_ms, input logic [1:0] fs,
                                         input logic [2:0] ch);
    item_t t;
    t = quiet_tick(at_ms);
    t.flight_state = fs;
    t.test_req = 1'b1;
    t.test_channel = ch;
    return t;
  endfunction

  task automatic test_test_fire();
    send_tick(test_request(32'd100, FS_STANDING, 3'd1));
    send_tick(test_request(32'd200, FS_STANDING, 3'd2));   // another test still running
    send_tick(quiet_tick(32'd1099));
    send_tick(quiet_tick(32'd1100));                        // pulse over, channel re-armed
    send_tick(test_request(32'd1200, FS_STANDING, 3'd0));
    send_tick(test_request(32'd1201, FS_STANDING, 3'd5));
    send_tick(test_request(32'd1202, FS_STANDING, 3'd7));
    send_tick(test_request(32'd1300, FS_OTHER, 3'd2));
    send_tick(test_request(32'd1301, FS_SPARE, 3'd2));
  endtask

  task automatic test_zero_pulse();
    wait_results_drained();
    set_reg(REG_PULSE_MS, '0);
    send_tick(test_request(32'd1400, FS_STANDING, 3'd4));
    wait_results_drained();
    set_reg(REG_PULSE_MS, CFG_W'(1000));
  endtask

  task automatic test_continuity();
    item_t t;
    t = quiet_tick(32'd1500);
    t.bat_mv = 16'd4096;
    // Each channel sits exactly on or just under one threshold.
    t.chan_mv_packed = {16'd3072, 16'd2048, 16'd1024, 16'd1023};
    send_tick(t);
    t = quiet_tick(32'd1501);
    t.bat_mv = 16'hFFFF;
    t.chan_mv_packed = {16'hFFFF, 16'd0, 16'hFFFF, 16'd0};
    send_tick(t);
    t = quiet_tick(32'd1502);
    t.bat_mv = '0;
    t.chan_mv_packed = '1;
    send_tick(t);
    t = quiet_tick(32'd1503);
    t.bat_empty = 1'b1;
    send_tick(t);
    t = quiet_tick(32'd1504);
    t.adc_valid = 1'b0;
    send_tick(t);
    t.time_ms = 32'd2503;
    send_tick(t);
    send_tick(test_request(32'd2600, FS_STANDING, 3'd3));  // driven channel reads zero
    send_tick(quiet_tick(32'd3600));
  endtask

  task automatic test_time_wrap();
    item_t t;
    t = test_request(32'hFFFF_FF00, FS_STANDING, 3'd2);
    t.adc_valid = 1'b0;
    send_tick(t);
    t = quiet_tick(32'h0000_02E7);
    t.adc_valid = 1'b0;
    send_tick(t);
    t.time_ms = 32'h0000_02E8;
    send_tick(t);
  endtask

  // Fires the pilot channel at apogee and leaves the backup channel for the random part.
  task automatic test_flight();
    item_t t;
    t = quiet_tick(32'h0000_1000);
    t.flight_state = FS_FREE_FALL;
    t.vel_up = -16'sd4999;
    t.alt_up = 24'sd3001;
    send_tick(t);
    t.time_ms = 32'h0000_1001;
    send_tick(t);
    t = quiet_tick(32'h0000_13E8);
    t.flight_state = FS_OTHER;
    send_tick(t);
    send_tick(test_request(32'h0000_13E9, FS_STANDING, 3'd1));
    now_ms = 32'h0000_2000;
  endtask

  task automatic random_tick();
    item_t t;
    int    pick;
    t = '0;
    pick = $urandom_range(0, 9);
    if (pick == 0) now_ms += $urandom;
    else if (pick < 4) now_ms += $urandom_range(0, 8);
    else if (pick < 7) now_ms += $urandom_range(0, regs.pulse_ms / 2 + 2);
    else now_ms += $urandom_range(0, regs.adc_dead_ms + 2);
    t.time_ms = now_ms;
    pick = $urandom_range(0, 19);
    t.flight_state = (pick < 15) ? FS_STANDING : (pick < 17) ? FS_OTHER :
                     (pick < 18) ? FS_SPARE : FS_FREE_FALL;
    if ($urandom_range(0, 1) == 0)
      t.vel_up = 16'(-int'(regs.descent_limit) + int'($urandom_range(0, 4)) - 2);
    else
      t.vel_up = 16'($urandom);
    if ($urandom_range(0, 1) == 0)
      t.alt_up = 24'(int'(regs.main_deploy_height) + int'($urandom_range(0, 4)) - 2);
    else
      t.alt_up = 24'($urandom);
    t.test_req = ($urandom_range(0, 9) < 4);
    pick = $urandom_range(0, 19);
    t.test_channel = (pick < 12) ? 3'($urandom_range(3, 4)) :
                     (pick < 17) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
    t.adc_valid = ($urandom_range(0, 4) != 0);
    t.bat_empty = ($urandom_range(0, 9) == 0);
    t.bat_mv = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(3000, 4200));
    for (int i = 0; i < 4; i++)
      t.chan_mv_packed[16*i +: 16] = ($urandom_range(0, 9) < 6) ?
                                     16'($urandom_range(0, t.bat_mv)) : 16'($urandom);
    send_tick(t);
  endtask

  task automatic test_random();
    cfg_t c;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: c = '{15'd5000, 23'd3000, 16'd1000, 16'd1000, 16'd16384, 16'd32768, 16'd49152};
        1: c = '{15'd0, 23'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0};
        2: c = '{15'h7FFF, 23'h7F_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        default: begin
          c.descent_limit      = 15'($urandom);
          c.main_deploy_height = 23'($urandom);
          c.pulse_ms    = 16'($urandom_range(1, 300));
          c.adc_dead_ms = 16'($urandom_range(1, 300));
          c.thr_both_ok   = 16'($urandom);
          c.thr_fuse_only = 16'($urandom);
          c.thr_ign_only  = 16'($urandom);
        end
      endcase
      configure(c);
      for (int n = 0; n < 325; n++) begin
        if (n % 100 == 0) begin
          tx_steady = ($urandom_range(0, 3) == 0);
          rx_steady = ($urandom_range(0, 3) == 0);
        end
        random_tick();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_test_fire();
    test_zero_pulse();
    test_continuity();
    test_time_wrap();
    test_flight();
    test_random();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && tick_results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
sv/pis_pkg.sv
sv/pis_mul.sv
sv/pis_cont.sv
sv/pis_seq.sv
sv/pyro_igniter_sequencer_core.sv
tb/sv/tb_pyro_igniter_sequencer_core.sv
